>>> hdl/array_list_engine_assert.svh
// ----------------------------------------------------------------------------
// array_list_engine_assert.svh
// assertion macros shared by the checker files of the array list engine
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define ALE_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define ALE_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// shared constants and codes of the array list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

  // default sizes of the element store
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_WORD_WIDTH = 32;

  // fixed port field widths
  localparam int KIND_W      = 4;
  localparam int POS_W       = 7;
  localparam int PORT_WORD_W = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;

  // found position reported when no entry matches (minus one)
  localparam logic [POS_W-1:0] FOUND_NONE = '1;

  // request operations
  typedef enum logic [KIND_W-1:0] {
    OP_GET          = 4'd0,
    OP_SET          = 4'd1,
    OP_APPEND       = 4'd2,
    OP_INSERT       = 4'd3,
    OP_REMOVE_AT    = 4'd4,
    OP_POP_LAST     = 4'd5,
    OP_GET_LAST     = 4'd6,
    OP_FIND         = 4'd7,
    OP_REMOVE_VALUE = 4'd8,
    OP_CLEAR        = 4'd9
  } op_kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

`default_nettype wire

>>> hdl/ale_mem.sv
// ----------------------------------------------------------------------------
// ale_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ale_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// request sequencer: decodes an item, walks the element store through its
// one read port and one write port, keeps the count and drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ctrl
  import ale_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  localparam int AW        = $clog2(CAPACITY)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // request channel
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire logic [KIND_W-1:0]       kind,
  input  wire logic [POS_W-1:0]        position,
  input  wire logic [PORT_WORD_W-1:0]  word_in,
  // result channel
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output logic [PORT_WORD_W-1:0]       word_out,
  output logic signed [POS_W-1:0]      found_position,
  output logic [STATUS_W-1:0]          status,
  output logic [COUNT_W-1:0]           count,
  output logic                         is_empty,
  // element store port
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [WORD_WIDTH-1:0]        mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  wire logic [WORD_WIDTH-1:0]   mem_rdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_INS,
    S_INS_LAST,
    S_RMV,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [KIND_W-1:0]       kind_q;
  logic [POS_W-1:0]        pos_q;
  logic [WORD_WIDTH-1:0]   w_q;
  logic [AW-1:0]           ptr;
  logic [WORD_WIDTH-1:0]   res_word;
  logic [POS_W-1:0]        res_found;
  status_t                 res_status;

  logic [EXT_W-1:0]        pos_e;
  logic [EXT_W-1:0]        cnt_e;
  logic [CNT_W-1:0]        cnt_m1;
  logic [AW-1:0]           pos_a;
  logic [AW-1:0]           cnt_a;
  logic [AW-1:0]           last_a;
  logic [AW-1:0]           ptr_inc;
  logic [AW-1:0]           ptr_dec;
  logic                    in_range;
  logic                    ins_range;
  logic                    full;
  logic                    empty;
  logic                    at_last;
  logic                    out_free;
  logic                    hit;

  // position and count compares
  assign pos_e     = EXT_W'(pos_q);
  assign cnt_e     = EXT_W'(cnt);
  assign cnt_m1    = cnt - 1'b1;
  assign pos_a     = AW'(pos_e);
  assign cnt_a     = AW'(cnt);
  assign last_a    = AW'(cnt_m1);
  assign ptr_inc   = ptr + 1'b1;
  assign ptr_dec   = ptr - 1'b1;
  assign in_range  = pos_e < cnt_e;
  assign ins_range = pos_e <= cnt_e;
  assign full      = cnt == CNT_W'(CAPACITY);
  assign empty     = cnt == '0;
  assign at_last   = ptr == last_a;
  assign hit       = mem_rdata == w_q;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = state != S_IDLE;

  // store port addressing per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = w_q;
    mem_raddr = ptr;
    unique case (state)
      S_DECODE: begin
        unique case (kind_q) inside
          OP_GET, OP_SET, OP_REMOVE_AT: begin
            mem_raddr = pos_a;
          end
          OP_APPEND: begin
            mem_we    = !full;
            mem_waddr = cnt_a;
          end
          OP_INSERT: begin
            if (ins_range && !full) begin
              if (pos_e == cnt_e) begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
              end else begin
                mem_raddr = last_a;
              end
            end
          end
          OP_POP_LAST, OP_GET_LAST: begin
            mem_raddr = last_a;
          end
          OP_FIND, OP_REMOVE_VALUE: begin
            mem_raddr = '0;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        if (kind_q == OP_SET) begin
          mem_we = 1'b1;
        end
        mem_raddr = ptr_inc;
      end
      S_INS: begin
        // move entry ptr up by one while reading the one below
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_dec;
      end
      S_INS_LAST: begin
        mem_we = 1'b1;
      end
      S_RMV: begin
        // move entry ptr down by one while reading the one above
        mem_we    = 1'b1;
        mem_waddr = ptr_dec;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_inc;
      end
      S_SCAN: begin
        mem_raddr = ptr_inc;
      end
      default: begin
      end
    endcase
  end

  // sequencer, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // result taken and no new one loaded this cycle
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q     <= kind;
            pos_q      <= position;
            w_q        <= WORD_WIDTH'(word_in);
            res_word   <= '0;
            res_found  <= '0;
            res_status <= ST_OK;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          unique case (kind_q) inside
            OP_GET, OP_SET, OP_REMOVE_AT: begin
              if (in_range) begin
                ptr   <= pos_a;
                state <= S_READ;
              end else begin
                res_status <= ST_RANGE;
              end
            end
            OP_APPEND: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            OP_INSERT: begin
              if (!ins_range) begin
                res_status <= ST_RANGE;
              end else if (full) begin
                res_status <= ST_FULL;
              end else if (pos_e == cnt_e) begin
                cnt <= cnt + 1'b1;
              end else begin
                ptr   <= last_a;
                state <= S_INS;
              end
            end
            OP_POP_LAST, OP_GET_LAST: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                ptr   <= last_a;
                state <= S_READ;
              end
            end
            OP_FIND, OP_REMOVE_VALUE: begin
              if (empty) begin
                res_status <= ST_NOTFOUND;
                res_found  <= FOUND_NONE;
              end else begin
                ptr   <= '0;
                state <= S_SCAN;
              end
            end
            OP_CLEAR: begin
              cnt <= '0;
            end
            default: begin
            end
          endcase
        end
        S_READ: begin
          res_word <= mem_rdata;
          state    <= S_DONE;
          if (kind_q == OP_POP_LAST) begin
            cnt <= cnt_m1;
          end
          if (kind_q == OP_REMOVE_AT) begin
            if (at_last) begin
              cnt <= cnt_m1;
            end else begin
              ptr   <= ptr_inc;
              state <= S_RMV;
            end
          end
        end
        S_INS: begin
          if (ptr == pos_a) begin
            state <= S_INS_LAST;
          end else begin
            ptr <= ptr_dec;
          end
        end
        S_INS_LAST: begin
          cnt   <= cnt + 1'b1;
          state <= S_DONE;
        end
        S_RMV: begin
          if (at_last) begin
            cnt   <= cnt_m1;
            state <= S_DONE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_found <= POS_W'(ptr);
            if (kind_q == OP_REMOVE_VALUE) begin
              res_word <= mem_rdata;
              if (at_last) begin
                cnt   <= cnt_m1;
                state <= S_DONE;
              end else begin
                ptr   <= ptr_inc;
                state <= S_RMV;
              end
            end else begin
              state <= S_DONE;
            end
          end else if (at_last) begin
            res_status <= ST_NOTFOUND;
            res_found  <= FOUND_NONE;
            state      <= S_DONE;
          end else begin
            ptr <= ptr_inc;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            word_out       <= PORT_WORD_W'(res_word);
            found_position <= res_found;
            status         <= res_status;
            count          <= COUNT_W'(cnt);
            is_empty       <= empty;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/array_list_engine.sv
// Inserts before the end and remove_at shift the entries past the position,
//   find and remove_value scan from the front, and remove_value then shifts the
//   entries past the hit. The store moves one entry a cycle over its read and
//   write ports.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: count and handshake cleared; store contents stay undefined, no clear pass.
// ----------------------------------------------------------------------------
// array_list_engine
// ordered word list in a fixed store with get, set, append, insert, remove,
// pop, search and clear requests
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine
  import ale_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [KIND_W-1:0]      kind,
  input  wire logic [POS_W-1:0]       position,
  input  wire logic [PORT_WORD_W-1:0] word_in,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output logic [PORT_WORD_W-1:0]      word_out,
  output logic signed [POS_W-1:0]     found_position,
  output logic [STATUS_W-1:0]         status,
  output logic [COUNT_W-1:0]          count,
  output logic                        is_empty
);

  localparam int AW = $clog2(CAPACITY);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  // sequencer
  ale_ctrl #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .kind           (kind),
    .position       (position),
    .word_in        (word_in),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .word_out       (word_out),
    .found_position (found_position),
    .status         (status),
    .count          (count),
    .is_empty       (is_empty),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // element store
  ale_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// port-level checks of the array list engine results, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_list_engine_assert.svh"

module ale_checker
  import ale_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_stall,
  input wire logic [PORT_WORD_W-1:0] word_out,
  input wire logic signed [POS_W-1:0] found_position,
  input wire logic [STATUS_W-1:0]    status,
  input wire logic [COUNT_W-1:0]     count,
  input wire logic                   is_empty
);

  // empty flag follows the count
  `ALE_ASSERT_IMP(a_empty_flag, clk, rst, rsp_valid, is_empty == (count == '0), "empty flag disagrees with count")

  // failed requests return no word
  `ALE_ASSERT_IMP(a_err_word, clk, rst, rsp_valid && (status != ST_OK), word_out == '0, "word on a failed item")

  // a miss reports minus one as its position
  `ALE_ASSERT_IMP(a_miss_pos, clk, rst, rsp_valid && (status == ST_NOTFOUND), found_position == FOUND_NONE, "miss without minus one")

  // full is only reported at capacity
  `ALE_ASSERT_IMP(a_full_cnt, clk, rst, rsp_valid && (status == ST_FULL), count == COUNT_W'(CAPACITY), "full below capacity")

  // a stalled result holds
  `ALE_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(word_out) && $stable(status) && $stable(count), "stalled result changed")

endmodule

bind array_list_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .word_out       (word_out),
  .found_position (found_position),
  .status         (status),
  .count          (count),
  .is_empty       (is_empty)
);

`default_nettype wire

>>> test/tb_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_engine
// Drives get, set, append, insert, remove, pop, search and clear requests
// into the list engine with bursty requests and patterned reply stalls.
// A shadow copy of the list predicts each reply; replies are compared field
// by field in order.
// ----------------------------------------------------------------------------

// one reply of the list engine
typedef struct packed {
  logic [31:0] word_val;
  logic [6:0]  found_pos;
  logic [2:0]  stat;
  logic [6:0]  cnt;
  logic        empty_flag;
} list_reply_t;

// shadow list: applies each taken item and checks replies in order
class list_tracker;
  logic [31:0] words [ale_pkg::DEF_CAPACITY];
  int nelem;
  list_reply_t due_replies[$];
  int unsigned errors;

  function new();
    nelem = 0;
    errors = 0;
  endfunction

  // take one entry out and close the gap
  function logic [31:0] take_at(int p);
    logic [31:0] w;
    int i;
    w = words[p];
    for (i = p; i + 1 < nelem; i++) begin
      words[i] = words[i + 1];
    end
    nelem--;
    return w;
  endfunction

  // apply one item to the shadow list and queue the reply it gives
  function void apply_op(logic [3:0] k, logic [6:0] p, logic [31:0] w);
    list_reply_t r;
    int hit;
    int i;
    r = '0;
    r.stat = ale_pkg::ST_OK;
    case (k)
      ale_pkg::OP_GET: begin
        if (p < nelem) r.word_val = words[p];
        else r.stat = ale_pkg::ST_RANGE;
      end
      ale_pkg::OP_SET: begin
        if (p < nelem) begin
          r.word_val = words[p];
          words[p] = w;
        end else begin
          r.stat = ale_pkg::ST_RANGE;
        end
      end
      ale_pkg::OP_APPEND: begin
        if (nelem >= ale_pkg::DEF_CAPACITY) begin
          r.stat = ale_pkg::ST_FULL;
        end else begin
          words[nelem] = w;
          nelem++;
        end
      end
      ale_pkg::OP_INSERT: begin
        if (p > nelem) begin
          r.stat = ale_pkg::ST_RANGE;
        end else if (nelem >= ale_pkg::DEF_CAPACITY) begin
          r.stat = ale_pkg::ST_FULL;
        end else begin
          for (i = nelem; i > p; i--) begin
            words[i] = words[i - 1];
          end
          words[p] = w;
          nelem++;
        end
      end
      ale_pkg::OP_REMOVE_AT: begin
        if (p < nelem) r.word_val = take_at(p);
        else r.stat = ale_pkg::ST_RANGE;
      end
      ale_pkg::OP_POP_LAST: begin
        if (nelem == 0) begin
          r.stat = ale_pkg::ST_EMPTY;
        end else begin
          nelem--;
          r.word_val = words[nelem];
        end
      end
      ale_pkg::OP_GET_LAST: begin
        if (nelem == 0) r.stat = ale_pkg::ST_EMPTY;
        else r.word_val = words[nelem - 1];
      end
      ale_pkg::OP_FIND, ale_pkg::OP_REMOVE_VALUE: begin
        hit = -1;
        for (i = 0; i < nelem && hit < 0; i++) begin
          if (words[i] == w) hit = i;
        end
        if (hit < 0) begin
          r.stat = ale_pkg::ST_NOTFOUND;
          r.found_pos = ale_pkg::FOUND_NONE;
        end else begin
          r.found_pos = hit[6:0];
          if (k == ale_pkg::OP_REMOVE_VALUE) r.word_val = take_at(hit);
        end
      end
      ale_pkg::OP_CLEAR: begin
        nelem = 0;
      end
      default: begin
      end
    endcase
    r.cnt = nelem[6:0];
    r.empty_flag = (nelem == 0);
    due_replies.push_back(r);
  endfunction

  function void report(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: error: %s expected %h, actual %h", $time, field, want, got);
  endfunction

  // compare one reply with the oldest outstanding prediction
  function void check_reply(list_reply_t got);
    list_reply_t want;
    if (due_replies.size() == 0) begin
      errors++;
      $display("%0t: error: reply with nothing outstanding, expected none, actual %h",
               $time, got);
    end else begin
      want = due_replies.pop_front();
      if (got.word_val !== want.word_val) report("word_out", want.word_val, got.word_val);
      if (got.found_pos !== want.found_pos)
        report("found_position", 32'(want.found_pos), 32'(got.found_pos));
      if (got.stat !== want.stat) report("status", 32'(want.stat), 32'(got.stat));
      if (got.cnt !== want.cnt) report("count", 32'(want.cnt), 32'(got.cnt));
      if (got.empty_flag !== want.empty_flag)
        report("is_empty", 32'(want.empty_flag), 32'(got.empty_flag));
    end
  endfunction
endclass

module tb_array_list_engine;
  import ale_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_OPS   = 750;

  // codes past the last operation, taken as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd10;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_SEARCH, MIX_ANY} op_mix_e;
  typedef enum int {BP_NONE, BP_COIN, BP_HEAVY, BP_PERIODIC} backpressure_e;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic [KIND_W-1:0]       kind = '0;
  logic [POS_W-1:0]        position = '0;
  logic [PORT_WORD_W-1:0]  word_in = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic [PORT_WORD_W-1:0]  word_out;
  logic signed [POS_W-1:0] found_position;
  logic [STATUS_W-1:0]     status;
  logic [COUNT_W-1:0]      count;
  logic                    is_empty;

  list_tracker   tracker;
  int            burst_left = 0;
  backpressure_e bp_mode = BP_NONE;
  int            bp_left = 0;
  int            bp_tick = 0;

  array_list_engine dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // sender pacing: bursts of random length with random gaps between
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // offer one item, hold it until taken, then note it in the shadow list
  task automatic send_op(logic [3:0] k, logic [6:0] p, logic [31:0] w);
    req_valid <= 1'b1;
    kind <= k;
    position <= p;
    word_in <= w;
    do @(posedge clk); while (!(req_valid && !req_stall));
    tracker.apply_op(k, p, w);
    pace_sender();
  endtask

  // hold off until every outstanding reply has come back
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_replies.size() != 0) @(posedge clk);
  endtask

  // operation mix per phase
  function automatic logic [3:0] pick_kind(op_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 50) return OP_APPEND;
        if (r < 85) return OP_INSERT;
      end
      MIX_SHRINK: begin
        if (r < 30) return OP_REMOVE_AT;
        if (r < 55) return OP_POP_LAST;
        if (r < 80) return OP_REMOVE_VALUE;
      end
      MIX_SEARCH: begin
        if (r < 30) return OP_FIND;
        if (r < 45) return OP_REMOVE_VALUE;
        if (r < 65) return OP_GET;
        if (r < 85) return OP_SET;
      end
      default: begin
      end
    endcase
    return 4'($urandom_range(0, 15));
  endfunction

  // mostly in or just past the list, sometimes anywhere
  function automatic logic [6:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 7'($urandom_range(0, tracker.nelem));
    if (r < 90) return 7'($urandom_range(0, 127));
    return (r < 95) ? 7'd64 : 7'd127;
  endfunction

  // small pool and words already held, so searches hit often
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return $urandom_range(1, 6);
      endcase
    end
    if (r < 55 && tracker.nelem > 0) return tracker.words[$urandom_range(0, tracker.nelem - 1)];
    return $urandom();
  endfunction

  // check every reply the block hands over
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      tracker.check_reply({word_out, found_position, status, count, is_empty});
    end
  end

  // reply-side stall, switching between patterns
  always @(posedge clk) begin
    if (bp_left == 0) begin
      bp_mode = backpressure_e'($urandom_range(0, 3));
      bp_left = $urandom_range(30, 300);
    end
    bp_left--;
    bp_tick++;
    case (bp_mode)
      BP_NONE: rsp_stall <= 1'b0;
      BP_COIN: rsp_stall <= 1'($urandom_range(0, 1));
      BP_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
      default: rsp_stall <= (bp_tick % 3 != 0);
    endcase
  end

  // watchdog on cycles with no item taken on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: error: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    op_mix_e    mix;
    int         phase_len;
    int         ops_sent;
    logic [3:0] k;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corners
    send_op(OP_GET, 7'd0, 32'h0);
    send_op(OP_POP_LAST, 7'd0, 32'h0);
    send_op(OP_GET_LAST, 7'd0, 32'h0);
    send_op(OP_FIND, 7'd0, 32'h0);
    send_op(OP_REMOVE_VALUE, 7'd0, 32'hFFFF_FFFF);
    send_op(OP_REMOVE_AT, 7'd0, 32'h0);
    // build a short list, inserts at front, at end and past the end
    send_op(OP_APPEND, 7'd0, 32'h0000_0000);
    send_op(OP_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 7'd0, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 7'd3, 32'h5A5A_5A5A);
    send_op(OP_INSERT, 7'd5, 32'h1111_1111);
    send_op(OP_INSERT, 7'd127, 32'h2222_2222);
    // reads, overwrite and searches
    send_op(OP_SET, 7'd1, 32'h1234_5678);
    send_op(OP_SET, 7'd64, 32'h3333_3333);
    send_op(OP_GET, 7'd2, 32'h0);
    send_op(OP_GET_LAST, 7'd0, 32'h0);
    send_op(OP_FIND, 7'd0, 32'hFFFF_FFFF);
    send_op(OP_FIND, 7'd0, 32'hDEAD_BEEF);
    // removals, spare codes and clear
    send_op(OP_REMOVE_VALUE, 7'd0, 32'h1234_5678);
    send_op(OP_REMOVE_AT, 7'd0, 32'h0);
    send_op(OP_REMOVE_AT, 7'd127, 32'h0);
    send_op(OP_POP_LAST, 7'd0, 32'h0);
    send_op(KIND_SPARE_LO, 7'd64, 32'hFFFF_FFFF);
    send_op(KIND_SPARE_HI, 7'd127, 32'h0);
    send_op(OP_CLEAR, 7'd0, 32'h0);
    drain_replies();

    // random phases, each with its own operation mix
    ops_sent = 0;
    while (ops_sent < RANDOM_OPS) begin
      mix = op_mix_e'($urandom_range(0, 3));
      phase_len = (mix == MIX_GROW) ? $urandom_range(60, 120) : $urandom_range(20, 80);
      repeat (phase_len) begin
        k = pick_kind(mix);
        send_op(k, pick_position(), pick_word());
        ops_sent++;
      end
      drain_replies();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.due_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ale_pkg.sv
hdl/ale_mem.sv
hdl/ale_ctrl.sv
hdl/array_list_engine.sv
hdl/ale_checker.sv
test/tb_array_list_engine.sv
